>>> src/fsh_pkg.sv
`timescale 1ns / 1ps
// Package for the first-seen symbol histogram: default sizes, item and result codes,
// and the helper functions used by the top level. Depends on nothing else.

package fsh_pkg;

	localparam int SYMBOLS_DEF    = 256;
	localparam int COUNT_BITS_DEF = 32;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 8;
	localparam int INDEX_W  = 8;
	localparam int SYMBOL_W = 8;
	localparam int FREQ_W   = 32;
	localparam int DIST_W   = 9;
	localparam int STATUS_W = 3;

	localparam logic [ACTION_W-1:0] ACT_COUNT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_HIT        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NEW        = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_READ_OK    = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_READ_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_CLEARED    = 3'd4;

	typedef logic [256*VALUE_W-1:0] mod_tab_t;

	// Builds the byte-to-symbol fold table for an alphabet of the given size.
	function automatic mod_tab_t mod_table(int symbols);
		mod_tab_t tab;
		int       r;
		tab = '0;
		r   = 0;
		for (int i = 0; i < 256; i++) begin
			tab[i*VALUE_W +: VALUE_W] = VALUE_W'(r);
			r = (r + 1 == symbols) ? 0 : r + 1;
		end
		return tab;
	endfunction

	// Saturates a count to the width of the frequency field.
	function automatic logic [FREQ_W-1:0] freq_field(logic [63:0] c);
		return (|c[63:32]) ? '1 : c[31:0];
	endfunction

endpackage

>>> src/fsh_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used by the first-seen symbol histogram for its index table and its entry table.
// No dependencies.

module fsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/first_seen_symbol_histogram.sv
`timescale 1ns / 1ps
// Top level of the first-seen symbol histogram: control sequencer, presence bits and
// result register. Depends on fsh_pkg and instantiates fsh_ram twice.
//
//  channel | dir | tdata (low bit up)                           | tuser
//  s_*     | in  | value[7:0]                                   | action[1:0]
//  m_*     | out | entry_index, symbol, frequency, distinct     | status[2:0]
//
// A read, a clear or a first sighting of a symbol finishes in the lookup state; a repeated
// symbol goes on to the count state, since its entry index must come out of the index
// RAM before its count can be read from the entry RAM.
// Reset clears the presence bits, the entry total and the sequencer; the RAMs are not
// cleared. A clear item empties the table through the presence bits.
// A finished result waits in the output register while the next request is accepted;
// the sequencer only holds when that register is still full.

module first_seen_symbol_histogram #(
	parameter int SYMBOLS    = fsh_pkg::SYMBOLS_DEF,
	parameter int COUNT_BITS = fsh_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // value[7:0]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // entry_index[7:0], symbol[15:8], frequency[47:16],
	                               // distinct[56:48], zero[63:57]
	output logic [2:0]  m_tuser    // status[2:0]
);

	localparam int SYM_W  = $clog2(SYMBOLS);
	localparam int DIST_W = $clog2(SYMBOLS + 1);
	localparam fsh_pkg::mod_tab_t MOD_TAB = fsh_pkg::mod_table(SYMBOLS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_CNT  = 2'd2;

	logic [1:0]                      state_q;
	logic [fsh_pkg::ACTION_W-1:0]    act_q;
	logic [fsh_pkg::VALUE_W-1:0]     value_q;
	logic [SYM_W-1:0]                sym_q;
	logic [SYM_W-1:0]                idx_q;
	logic [SYMBOLS-1:0]              present_q;
	logic [DIST_W-1:0]               distinct_q;
	logic                            m_tvalid_q;
	logic [63:0]                     m_tdata_q;
	logic [fsh_pkg::STATUS_W-1:0]    m_tuser_q;

	logic                            accept;
	logic                            out_free;
	logic [fsh_pkg::VALUE_W-1:0]     in_value;
	logic [fsh_pkg::VALUE_W-1:0]     in_fold;
	logic [SYM_W-1:0]                in_sym;
	logic                            is_count;
	logic                            present_hit;
	logic                            look_done;
	logic                            cnt_done;
	logic                            done;
	logic                            done_new;
	logic                            done_clear;
	logic [SYM_W-1:0]                idx_raddr;
	logic [SYM_W-1:0]                ent_raddr;
	logic [SYM_W-1:0]                idx_rd;
	logic [SYM_W+COUNT_BITS-1:0]     ent_rd;
	logic [SYM_W-1:0]                sym_rd;
	logic [COUNT_BITS-1:0]           cnt_rd;
	logic [COUNT_BITS-1:0]           cnt_inc;
	logic                            cnt_we;
	logic [SYM_W-1:0]                cnt_waddr;
	logic [COUNT_BITS-1:0]           cnt_wdata;
	logic                            read_ok;
	logic [fsh_pkg::INDEX_W-1:0]     res_idx;
	logic [fsh_pkg::SYMBOL_W-1:0]    res_sym;
	logic [COUNT_BITS-1:0]           res_cnt;
	logic [fsh_pkg::DIST_W-1:0]      res_dist;
	logic [fsh_pkg::STATUS_W-1:0]    res_stat;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign in_value = s_tdata[fsh_pkg::VALUE_W-1:0];
	assign in_fold  = MOD_TAB[{in_value, 3'b000} +: fsh_pkg::VALUE_W];
	assign in_sym   = in_fold[SYM_W-1:0];

	assign is_count    = (act_q == fsh_pkg::ACT_COUNT);
	assign present_hit = present_q[sym_q];
	assign look_done   = (state_q == S_LOOK) && !(is_count && present_hit) && out_free;
	assign cnt_done    = (state_q == S_CNT) && out_free;
	assign done        = look_done || cnt_done;
	assign done_new    = look_done && is_count;
	assign done_clear  = look_done && (act_q == fsh_pkg::ACT_CLEAR);

	assign cnt_inc = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
	assign read_ok = ({1'b0, value_q} < fsh_pkg::DIST_W'(distinct_q));

	assign idx_raddr = (state_q == S_IDLE) ? in_sym : sym_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:  ent_raddr = in_value[SYM_W-1:0];
			S_LOOK:  ent_raddr = (is_count && present_hit) ? idx_rd : value_q[SYM_W-1:0];
			S_CNT:   ent_raddr = idx_q;
			default: ent_raddr = '0;
		endcase
	end

	// An entry holds its symbol beside its count; a repeat rewrites the same symbol.
	assign cnt_we    = done_new || cnt_done;
	assign cnt_waddr = cnt_done ? idx_q : distinct_q[SYM_W-1:0];
	assign cnt_wdata = cnt_done ? cnt_inc : COUNT_BITS'(1);

	assign sym_rd = ent_rd[SYM_W+COUNT_BITS-1:COUNT_BITS];
	assign cnt_rd = ent_rd[COUNT_BITS-1:0];

	fsh_ram #(
		.WIDTH(SYM_W),
		.DEPTH(SYMBOLS)
	) u_index_ram (
		.clk  (clk),
		.we   (done_new),
		.waddr(sym_q),
		.wdata(distinct_q[SYM_W-1:0]),
		.raddr(idx_raddr),
		.rdata(idx_rd)
	);

	fsh_ram #(
		.WIDTH(SYM_W + COUNT_BITS),
		.DEPTH(SYMBOLS)
	) u_entry_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata({sym_q, cnt_wdata}),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	always_comb begin
		res_idx  = '0;
		res_sym  = '0;
		res_cnt  = '0;
		res_dist = fsh_pkg::DIST_W'(distinct_q);
		res_stat = fsh_pkg::STAT_CLEARED;
		if (state_q == S_CNT) begin
			res_idx  = fsh_pkg::INDEX_W'(idx_q);
			res_sym  = fsh_pkg::SYMBOL_W'(sym_q);
			res_cnt  = cnt_inc;
			res_stat = fsh_pkg::STAT_HIT;
		end else begin
			case (act_q) inside
				fsh_pkg::ACT_COUNT: begin
					res_idx  = fsh_pkg::INDEX_W'(distinct_q[SYM_W-1:0]);
					res_sym  = fsh_pkg::SYMBOL_W'(sym_q);
					res_cnt  = COUNT_BITS'(1);
					res_dist = fsh_pkg::DIST_W'(distinct_q) + 1'b1;
					res_stat = fsh_pkg::STAT_NEW;
				end
				fsh_pkg::ACT_CLEAR: begin
					res_dist = '0;
					res_stat = fsh_pkg::STAT_CLEARED;
				end
				fsh_pkg::ACT_READ, fsh_pkg::ACT_SPARE: begin
					res_idx = value_q;
					if (read_ok) begin
						res_sym  = fsh_pkg::SYMBOL_W'(sym_rd);
						res_cnt  = cnt_rd;
						res_stat = fsh_pkg::STAT_READ_OK;
					end else begin
						res_stat = fsh_pkg::STAT_READ_EMPTY;
					end
				end
				default: begin
					res_stat = fsh_pkg::STAT_CLEARED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			present_q  <= '0;
			distinct_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (is_count && present_hit) begin
						state_q <= S_CNT;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_CNT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done_new) begin
				present_q[sym_q] <= 1'b1;
				distinct_q       <= distinct_q + 1'b1;
			end else if (done_clear) begin
				present_q  <= '0;
				distinct_q <= '0;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= s_tuser;
			value_q <= in_value;
			sym_q   <= in_sym;
		end
		if (state_q == S_LOOK) begin
			idx_q <= idx_rd;
		end
		if (done) begin
			m_tdata_q <= {7'b0, res_dist, fsh_pkg::freq_field(64'(res_cnt)), res_sym, res_idx};
			m_tuser_q <= res_stat;
		end
	end

`ifndef SYNTHESIS
	a_distinct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		distinct_q <= DIST_W'(SYMBOLS))
		else $error("entry total exceeds alphabet size");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_LOOK))
		else $error("accepted request did not start a table lookup");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == S_IDLE) && m_tvalid_q)
		else $error("finished request did not release the sequencer");

	a_new_present: assert property (@(posedge clk) disable iff (!arst_n)
		done_new |=> present_q[$past(sym_q)])
		else $error("new symbol not marked present");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_clear |=> (distinct_q == '0) && (present_q == '0))
		else $error("clear left entries in the table");
`endif

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for first_seen_symbol_histogram: a directed table, a sweep that fills
// the table, then random traffic, scored against a built-in table predictor or against
// fixed results in directed rows. Depends on fsh_pkg and the block's RTL only.

module tb_top;

	localparam int SYMBOLS    = fsh_pkg::SYMBOLS_DEF;
	localparam int COUNT_BITS = fsh_pkg::COUNT_BITS_DEF;
	localparam logic [63:0] COUNT_LIMIT =
		(COUNT_BITS >= 64) ? '1 : ((64'd1 << COUNT_BITS) - 64'd1);
	localparam int NPROBE  = 24;
	localparam int NRANDOM = 720;
	localparam int NQUIET  = 160;

	typedef struct packed {
		logic [fsh_pkg::INDEX_W-1:0]  entry_index;
		logic [fsh_pkg::SYMBOL_W-1:0] symbol;
		logic [fsh_pkg::FREQ_W-1:0]   frequency;
		logic [fsh_pkg::DIST_W-1:0]   distinct;
		logic [fsh_pkg::STATUS_W-1:0] status;
	} hist_result_t;

	typedef struct packed {
		logic [fsh_pkg::ACTION_W-1:0] action;
		logic [fsh_pkg::VALUE_W-1:0]  value;
		bit                           typed;
		hist_result_t                 want;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	// Predictor state: the histogram as the block should hold it.
	bit   [255:0]                 seen;
	logic [fsh_pkg::INDEX_W-1:0]  index_of [256];
	logic [fsh_pkg::SYMBOL_W-1:0] symbol_at [256];
	logic [63:0]                  tally [256];
	logic [fsh_pkg::DIST_W-1:0]   entries;

	hist_result_t pending_results[$];
	hist_result_t got, want;
	int           errors = 0;
	int           accepted = 0;
	int           status_seen [8];
	int           peak_entries = 0;
	int           stall_left = 0;
	bit           quiet = 1'b0;

	first_seen_symbol_histogram #(.SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [fsh_pkg::FREQ_W-1:0] saturate_freq(logic [63:0] c);
		return (|c[63:32]) ? '1 : c[31:0];
	endfunction

	function automatic hist_result_t histogram_step(logic [fsh_pkg::ACTION_W-1:0] act,
	                                                logic [fsh_pkg::VALUE_W-1:0] val);
		hist_result_t                r;
		logic [7:0]                  sym;
		logic [fsh_pkg::INDEX_W-1:0] idx;
		r = '0;
		case (act)
			fsh_pkg::ACT_COUNT: begin
				sym = 8'(int'(val) % SYMBOLS);
				if (seen[sym]) begin
					idx = index_of[sym];
					if (tally[idx] < COUNT_LIMIT)
						tally[idx] = tally[idx] + 64'd1;
					r = {idx, sym, saturate_freq(tally[idx]), entries, fsh_pkg::STAT_HIT};
				end else begin
					idx = entries[fsh_pkg::INDEX_W-1:0];
					seen[sym] = 1'b1;
					index_of[sym] = idx;
					symbol_at[idx] = sym;
					tally[idx] = 64'd1;
					entries = entries + 1'b1;
					r = {idx, sym, 32'd1, entries, fsh_pkg::STAT_NEW};
				end
			end
			fsh_pkg::ACT_CLEAR: begin
				seen = '0;
				entries = '0;
				r = {8'd0, 8'd0, 32'd0, 9'd0, fsh_pkg::STAT_CLEARED};
			end
			default: begin
				if ({1'b0, val} < entries)
					r = {val, symbol_at[val], saturate_freq(tally[val]), entries,
					     fsh_pkg::STAT_READ_OK};
				else
					r = {val, 8'd0, 32'd0, entries, fsh_pkg::STAT_READ_EMPTY};
			end
		endcase
		return r;
	endfunction

	function automatic probe_row_t row(logic [fsh_pkg::ACTION_W-1:0] act,
	                                   logic [fsh_pkg::VALUE_W-1:0] val,
	                                   bit typed, hist_result_t w);
		return {act, val, typed, w};
	endfunction

	task automatic report(input string what, input logic [63:0] g, input logic [63:0] w);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, g, w, $time);
	endtask

	task automatic push_request(input logic [fsh_pkg::ACTION_W-1:0] act,
	                            input logic [fsh_pkg::VALUE_W-1:0] val,
	                            input bit typed, input hist_result_t typed_want);
		bit           taken;
		hist_result_t r;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= val;
		s_tuser  <= act;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			if (taken) begin
				r = histogram_step(act, val);
				pending_results.push_back(typed ? typed_want : r);
				accepted++;
				if (entries > peak_entries)
					peak_entries = int'(entries);
			end
			@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Results are taken at the falling edge, where the handshake for the next rising edge
	// is already settled.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[15:8], m_tdata[47:16], m_tdata[56:48], m_tuser};
			status_seen[got.status]++;
			if (pending_results.size() == 0) begin
				report("result with nothing pending", 64'(got), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.entry_index != want.entry_index)
					report("entry_index", 64'(got.entry_index), 64'(want.entry_index));
				if (got.symbol != want.symbol)
					report("symbol", 64'(got.symbol), 64'(want.symbol));
				if (got.frequency != want.frequency)
					report("frequency", 64'(got.frequency), 64'(want.frequency));
				if (got.distinct != want.distinct)
					report("distinct", 64'(got.distinct), 64'(want.distinct));
				if (got.status != want.status)
					report("status", 64'(got.status), 64'(want.status));
			end
		end
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		probe_row_t                   probes [NPROBE];
		logic [fsh_pkg::VALUE_W-1:0]  order [256];
		logic [fsh_pkg::VALUE_W-1:0]  tmp, val;
		logic [fsh_pkg::ACTION_W-1:0] act;
		int                           j, k;

		seen = '0;
		entries = '0;
		foreach (status_seen[i])
			status_seen[i] = 0;

		probes = '{
			row(fsh_pkg::ACT_READ,  8'd0,   1'b1,
			    {8'd0,   8'd0, 32'd0, 9'd0, fsh_pkg::STAT_READ_EMPTY}),
			row(fsh_pkg::ACT_READ,  8'd255, 1'b1,
			    {8'd255, 8'd0, 32'd0, 9'd0, fsh_pkg::STAT_READ_EMPTY}),
			row(fsh_pkg::ACT_CLEAR, 8'd0,   1'b1,
			    {8'd0,   8'd0, 32'd0, 9'd0, fsh_pkg::STAT_CLEARED}),
			row(fsh_pkg::ACT_COUNT, 8'd0,   1'b1,
			    {8'd0,   8'd0, 32'd1, 9'd1, fsh_pkg::STAT_NEW}),
			row(fsh_pkg::ACT_COUNT, 8'd0,   1'b1,
			    {8'd0,   8'd0, 32'd2, 9'd1, fsh_pkg::STAT_HIT}),
			row(fsh_pkg::ACT_COUNT, 8'd255, 1'b0, '0),
			row(fsh_pkg::ACT_COUNT, 8'hAA,  1'b0, '0),
			row(fsh_pkg::ACT_COUNT, 8'h55,  1'b0, '0),
			row(fsh_pkg::ACT_COUNT, 8'd255, 1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd0,   1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd1,   1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd3,   1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd4,   1'b0, '0),
			row(fsh_pkg::ACT_SPARE, 8'd1,   1'b0, '0),
			row(fsh_pkg::ACT_SPARE, 8'd200, 1'b0, '0),
			row(fsh_pkg::ACT_COUNT, 8'h80,  1'b0, '0),
			row(fsh_pkg::ACT_COUNT, 8'h01,  1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd255, 1'b0, '0),
			row(fsh_pkg::ACT_CLEAR, 8'hFF,  1'b1,
			    {8'd0,   8'd0, 32'd0, 9'd0, fsh_pkg::STAT_CLEARED}),
			row(fsh_pkg::ACT_READ,  8'd0,   1'b1,
			    {8'd0,   8'd0, 32'd0, 9'd0, fsh_pkg::STAT_READ_EMPTY}),
			row(fsh_pkg::ACT_COUNT, 8'h55,  1'b0, '0),
			row(fsh_pkg::ACT_READ,  8'd0,   1'b0, '0),
			row(fsh_pkg::ACT_SPARE, 8'd0,   1'b0, '0),
			row(fsh_pkg::ACT_CLEAR, 8'h5A,  1'b1,
			    {8'd0,   8'd0, 32'd0, 9'd0, fsh_pkg::STAT_CLEARED})
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			push_request(probes[i].action, probes[i].value, probes[i].typed, probes[i].want);

		// Let the pipeline drain completely before the table is filled.
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);

		// Fill the whole table with every byte in shuffled order, then touch it while full.
		for (int i = 0; i < 256; i++)
			order[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		push_request(fsh_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, '0);
		for (int i = 0; i < 256; i++)
			push_request(fsh_pkg::ACT_COUNT, order[i], 1'b0, '0);
		push_request(fsh_pkg::ACT_READ, 8'd255, 1'b0, '0);
		push_request(fsh_pkg::ACT_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
		push_request(fsh_pkg::ACT_COUNT, 8'($urandom_range(0, 255)), 1'b0, '0);

		for (int i = 0; i < NRANDOM; i++) begin
			if (i == NRANDOM - NQUIET)
				quiet = 1'b1;
			k = $urandom_range(0, 99);
			if (k < 55 || k >= 95) begin
				act = fsh_pkg::ACT_COUNT;
				val = (k >= 95 || $urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				                                             : 8'($urandom_range(0, 31));
			end else if (k < 93) begin
				act = (k < 85) ? fsh_pkg::ACT_READ : fsh_pkg::ACT_SPARE;
				val = (entries != 0 && $urandom_range(0, 3) != 0)
				      ? 8'($urandom_range(0, entries - 1)) : 8'($urandom_range(0, 255));
			end else begin
				act = fsh_pkg::ACT_CLEAR;
				val = 8'($urandom_range(0, 255));
			end
			push_request(act, val, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d requests: %0d repeat counts, %0d new entries, %0d reads, %0d empty reads",
		         accepted, status_seen[fsh_pkg::STAT_HIT], status_seen[fsh_pkg::STAT_NEW],
		         status_seen[fsh_pkg::STAT_READ_OK], status_seen[fsh_pkg::STAT_READ_EMPTY]);
		$display("%0d clears, largest table %0d entries", status_seen[fsh_pkg::STAT_CLEARED],
		         peak_entries);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
